// ===== rtl/core/vqdm_pkg.sv =====
`default_nettype none

package vqdm_pkg;

    // Largest ring the 8-bit index fields can address.
    localparam int MAX_SLOTS = 256;
    // Depth of the descriptor tables; expected to be a power of two.
    localparam int DEF_RING_DEPTH = 256;
    localparam logic [3:0] CFG_LG_RESET = 4'd8;

    localparam int IN_DATA_W = 264;
    localparam int OUT_DATA_W = 240;

    // Descriptor entry states
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_AVAIL = 2'd2;

    localparam logic [2:0] FL_NEXT = 3'b001;
    localparam logic [2:0] FL_KEEP = 3'b110;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_CPL     = 2'd1,
        ACT_RD_DESC = 2'd2,
        ACT_RD_AVL  = 2'd3
    } act_e_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_OPEN    = 2'd1,
        STS_REFUSED = 2'd2,
        STS_BROKEN  = 2'd3
    } status_e_t;

    typedef struct packed {
        logic [63:0] tag;
        logic [1:0]  state;
        logic [8:0]  link;
        logic [7:0]  next;
        logic [2:0]  flags;
        logic [31:0] len;
        logic [63:0] addr;
    } desc_entry_t;

    typedef struct packed {
        act_e_t      action;
        logic [63:0] desc_addr;
        logic [31:0] desc_len;
        logic [15:0] desc_flags;
        logic [8:0]  chain_count;
        logic [63:0] context_tag;
        logic [31:0] used_id;
        logic [31:0] used_len;
        logic [7:0]  read_index;
    } in_beat_t;

    typedef struct packed {
        status_e_t   status;
        logic [7:0]  head_index;
        logic [15:0] avail_count;
        logic [63:0] done_tag;
        logic [31:0] done_len;
        logic [8:0]  free_count;
        logic [63:0] out_addr;
        logic [31:0] out_len;
        logic [2:0]  out_flags;
        logic [7:0]  out_next;
    } result_t;

    function automatic logic [8:0] calc_n(input logic [3:0] lg, input logic [8:0] max_n);
        logic [3:0] c;
        logic [8:0] p;
        c = lg;
        if (c < 4'd1) c = 4'd1;
        if (c > 4'd8) c = 4'd8;
        p = 9'd1 << c;
        return (p > max_n) ? max_n : p;
    endfunction

    // Value of a descriptor entry that was never written since init.
    function automatic desc_entry_t init_entry(input logic [7:0] idx, input logic [8:0] n);
        desc_entry_t e;
        logic [8:0]  nx;
        e = '0;
        nx = {1'b0, idx} + 9'd1;
        e.link = (nx < n) ? nx : n;
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vqdm_ram.sv =====
`default_nettype none

module vqdm_ram
    import vqdm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     clear,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    output logic                          rd_valid
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             hit;

    // same-cycle write to the read address is forwarded
    assign hit = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= hit ? wr_data : mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= hit || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vqdm_engine.sv =====
`default_nettype none

module vqdm_engine
    import vqdm_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_beat_t   in_beat,
    output logic            res_valid,
    input  wire logic       res_take,
    output result_t         res
);

    localparam int MEM_DEPTH = (RING_DEPTH > MAX_SLOTS) ? MAX_SLOTS : RING_DEPTH;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [8:0] MAX_N = 9'(MEM_DEPTH);
    localparam int DW = $bits(desc_entry_t);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_DESC, S_RD_AVL, S_ADD_CHK,
        S_ADD_LINK, S_ADD_TAIL, S_PUB, S_CPL, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  lg_reg;
    logic [8:0]  fl_top_reg, fl_top_next;
    logic [8:0]  free_total_reg, free_total_next;
    logic [15:0] avail_cnt_reg, avail_cnt_next;
    logic        broken_reg, broken_next;
    logic [8:0]  chain_rem_reg, chain_rem_next;
    logic [7:0]  chain_head_reg, chain_head_next;
    logic [7:0]  chain_prev_reg, chain_prev_next;
    logic [7:0]  cur_reg, cur_next;
    logic [8:0]  walk_reg, walk_next;
    logic [63:0] tag_reg, tag_next;
    in_beat_t    beat_reg, beat_next;
    result_t     res_reg, res_next;

    logic [8:0]  n9;
    logic [8:0]  n_cfg;
    logic [7:0]  mask8;
    logic [7:0]  slot8;
    logic [7:0]  avl_slot8;
    logic [8:0]  rem_v;
    logic [63:0] tag_now;
    logic        first;

    logic        d_we, d_re, d_rvalid;
    logic [AW-1:0] d_waddr, d_raddr;
    desc_entry_t d_wdata, d_rdata, ent;
    logic [DW-1:0] d_rbits;

    logic        a_we, a_re, a_rvalid;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [7:0]  a_wdata, a_rdata;

    vqdm_ram #(.WIDTH(DW), .DEPTH(MEM_DEPTH)) u_desc_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_wr_en),
        .wr_en    (d_we),
        .wr_addr  (d_waddr),
        .wr_data  (d_wdata),
        .rd_en    (d_re),
        .rd_addr  (d_raddr),
        .rd_data  (d_rbits),
        .rd_valid (d_rvalid)
    );

    vqdm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_avail_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_wr_en),
        .wr_en    (a_we),
        .wr_addr  (a_waddr),
        .wr_data  (a_wdata),
        .rd_en    (a_re),
        .rd_addr  (a_raddr),
        .rd_data  (a_rdata),
        .rd_valid (a_rvalid)
    );

    assign d_rdata   = desc_entry_t'(d_rbits);
    assign n9        = calc_n(lg_reg, MAX_N);
    assign n_cfg     = calc_n(cfg_wr_data, MAX_N);
    assign mask8     = 8'(n9 - 9'd1);
    assign slot8     = beat_reg.read_index & mask8;
    assign avl_slot8 = avail_cnt_reg[7:0] & mask8;
    // untouched entries read as their init value
    assign ent       = d_rvalid ? d_rdata : init_entry(cur_reg, n9);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res = res_reg;
        res.avail_count = avail_cnt_reg;
        res.free_count  = free_total_reg;
    end

    always_comb begin
        state_next      = state_reg;
        fl_top_next     = fl_top_reg;
        free_total_next = free_total_reg;
        avail_cnt_next  = avail_cnt_reg;
        broken_next     = broken_reg;
        chain_rem_next  = chain_rem_reg;
        chain_head_next = chain_head_reg;
        chain_prev_next = chain_prev_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        tag_next        = tag_reg;
        beat_next       = beat_reg;
        res_next        = res_reg;
        d_we = 1'b0; d_waddr = cur_reg[AW-1:0]; d_wdata = ent;
        d_re = 1'b0; d_raddr = cur_reg[AW-1:0];
        a_we = 1'b0; a_waddr = avl_slot8[AW-1:0]; a_wdata = chain_head_reg;
        a_re = 1'b0; a_raddr = slot8[AW-1:0];
        first   = (chain_rem_reg == 9'd0);
        rem_v   = first ? beat_reg.chain_count : chain_rem_reg;
        tag_now = (walk_reg == 9'd0) ? ent.tag : tag_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    beat_next  = in_beat;
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (beat_reg.action)
                    ACT_ADD: begin
                        if (broken_reg) begin
                            res_next.status = STS_BROKEN;
                            state_next = S_DONE;
                        end else if (first && (beat_reg.chain_count == 9'd0 ||
                                beat_reg.chain_count > n9 ||
                                beat_reg.chain_count > free_total_reg)) begin
                            res_next.status = STS_REFUSED;
                            state_next = S_DONE;
                        end else if (fl_top_reg >= n9) begin
                            broken_next = 1'b1;
                            res_next.status = STS_BROKEN;
                            state_next = S_DONE;
                        end else begin
                            d_re       = 1'b1;
                            d_raddr    = fl_top_reg[AW-1:0];
                            cur_next   = fl_top_reg[7:0];
                            state_next = S_ADD_CHK;
                        end
                    end
                    ACT_CPL: begin
                        if (broken_reg) begin
                            res_next.status = STS_BROKEN;
                            state_next = S_DONE;
                        end else if (beat_reg.used_id >= 32'(n9)) begin
                            broken_next = 1'b1;
                            res_next.status = STS_BROKEN;
                            state_next = S_DONE;
                        end else begin
                            d_re       = 1'b1;
                            d_raddr    = beat_reg.used_id[AW-1:0];
                            cur_next   = beat_reg.used_id[7:0];
                            walk_next  = 9'd0;
                            state_next = S_CPL;
                        end
                    end
                    ACT_RD_DESC: begin
                        d_re       = 1'b1;
                        d_raddr    = slot8[AW-1:0];
                        cur_next   = slot8;
                        state_next = S_RD_DESC;
                    end
                    ACT_RD_AVL: begin
                        a_re       = 1'b1;
                        state_next = S_RD_AVL;
                    end
                endcase
            end
            S_RD_DESC: begin
                res_next.status    = broken_reg ? STS_BROKEN : STS_DONE;
                res_next.out_addr  = ent.addr;
                res_next.out_len   = ent.len;
                res_next.out_flags = ent.flags;
                res_next.out_next  = ent.next;
                state_next = S_DONE;
            end
            S_RD_AVL: begin
                res_next.status     = broken_reg ? STS_BROKEN : STS_DONE;
                res_next.head_index = a_rvalid ? a_rdata : 8'd0;
                state_next = S_DONE;
            end
            S_ADD_CHK: begin
                if (ent.state != ST_FREE) begin
                    broken_next = 1'b1;
                    res_next.status = STS_BROKEN;
                    state_next = S_DONE;
                end else begin
                    d_we          = 1'b1;
                    d_wdata.addr  = beat_reg.desc_addr;
                    d_wdata.len   = beat_reg.desc_len;
                    d_wdata.flags = beat_reg.desc_flags[2:0] & FL_KEEP;
                    d_wdata.next  = 8'd0;
                    d_wdata.state = ST_BUILD;
                    d_wdata.tag   = first ? beat_reg.context_tag : ent.tag;
                    fl_top_next     = ent.link;
                    free_total_next = free_total_reg - 9'd1;
                    chain_rem_next  = rem_v - 9'd1;
                    chain_prev_next = cur_reg;
                    if (first) begin
                        chain_head_next = cur_reg;
                        state_next = S_ADD_TAIL;
                    end else begin
                        d_re       = 1'b1;
                        d_raddr    = chain_prev_reg[AW-1:0];
                        cur_next   = chain_prev_reg;
                        state_next = S_ADD_LINK;
                    end
                end
            end
            S_ADD_LINK: begin
                // link the previous element to the new one
                d_we          = 1'b1;
                d_wdata.next  = chain_prev_reg;
                d_wdata.flags = ent.flags | FL_NEXT;
                state_next    = S_ADD_TAIL;
            end
            S_ADD_TAIL: begin
                if (chain_rem_reg != 9'd0) begin
                    res_next.status     = STS_OPEN;
                    res_next.head_index = chain_head_reg;
                    state_next = S_DONE;
                end else begin
                    d_re       = 1'b1;
                    d_raddr    = chain_head_reg[AW-1:0];
                    cur_next   = chain_head_reg;
                    walk_next  = 9'd0;
                    state_next = S_PUB;
                end
            end
            S_PUB: begin
                d_we          = 1'b1;
                d_wdata.state = ST_AVAIL;
                if (ent.flags[0] == 1'b0 || walk_reg + 9'd1 >= n9) begin
                    a_we           = 1'b1;
                    avail_cnt_next = avail_cnt_reg + 16'd1;
                    res_next.status     = STS_DONE;
                    res_next.head_index = chain_head_reg;
                    state_next = S_DONE;
                end else begin
                    d_re      = 1'b1;
                    d_raddr   = ent.next[AW-1:0];
                    cur_next  = ent.next;
                    walk_next = walk_reg + 9'd1;
                end
            end
            S_CPL: begin
                if (walk_reg == 9'd0) begin
                    tag_next = ent.tag;
                end
                if (ent.state != ST_AVAIL || (ent.flags[0] && {1'b0, ent.next} >= n9) ||
                        free_total_reg >= n9) begin
                    broken_next = 1'b1;
                    res_next.status = STS_BROKEN;
                    state_next = S_DONE;
                end else begin
                    d_we            = 1'b1;
                    d_wdata.state   = ST_FREE;
                    d_wdata.tag     = 64'd0;
                    d_wdata.link    = fl_top_reg;
                    fl_top_next     = {1'b0, cur_reg};
                    free_total_next = free_total_reg + 9'd1;
                    if (ent.flags[0] == 1'b0) begin
                        res_next.status     = STS_DONE;
                        res_next.head_index = beat_reg.used_id[7:0];
                        res_next.done_tag   = tag_now;
                        res_next.done_len   = beat_reg.used_len;
                        state_next = S_DONE;
                    end else if (walk_reg + 9'd1 >= n9) begin
                        broken_next = 1'b1;
                        res_next.status = STS_BROKEN;
                        state_next = S_DONE;
                    end else begin
                        d_re      = 1'b1;
                        d_raddr   = ent.next[AW-1:0];
                        cur_next  = ent.next;
                        walk_next = walk_reg + 9'd1;
                    end
                end
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        walk_reg <= walk_next;
        tag_reg  <= tag_next;
        beat_reg <= beat_next;
        res_reg  <= res_next;
        if (!aresetn || cfg_wr_en) begin
            state_reg      <= S_IDLE;
            lg_reg         <= aresetn ? cfg_wr_data : CFG_LG_RESET;
            fl_top_reg     <= 9'd0;
            free_total_reg <= aresetn ? n_cfg : calc_n(CFG_LG_RESET, MAX_N);
            avail_cnt_reg  <= 16'd0;
            broken_reg     <= 1'b0;
            chain_rem_reg  <= 9'd0;
            chain_head_reg <= 8'd0;
            chain_prev_reg <= 8'd0;
        end else begin
            state_reg      <= state_next;
            fl_top_reg     <= fl_top_next;
            free_total_reg <= free_total_next;
            avail_cnt_reg  <= avail_cnt_next;
            broken_reg     <= broken_next;
            chain_rem_reg  <= chain_rem_next;
            chain_head_reg <= chain_head_next;
            chain_prev_reg <= chain_prev_next;
        end
    end

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= n9)
        else $error("free count above ring size");

    a_broken_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        broken_reg && !cfg_wr_en |=> broken_reg)
        else $error("broken flag cleared without reinit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && !cfg_wr_en |=> !in_ready)
        else $error("accepted a beat while busy");

    a_chain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_rem_reg <= n9)
        else $error("open chain longer than ring");

endmodule

`default_nettype wire

// ===== rtl/core/virtqueue_descriptor_manager.sv =====
// Split virtqueue, driver side: descriptor table, LIFO free list and avail ring.
// Input beats (s_*): tuser carries the action (add element, complete used entry,
// read descriptor, read avail slot); tdata carries the operands. Every input beat
// yields exactly one result beat on m_* with status in tuser.
// cfg_wr_en/cfg_wr_data write ring_size_log2 and re-initialize the whole queue;
// write it only while the block is idle.
// Reads pass decode and one memory read before the result. An add element
// pops the free list and, past the first, links the previous element to it;
// the last element of a chain then walks it to mark it available; a completion
// walks the chain to free it. One item is in work at a time: the chain walk,
// one descriptor-memory read-modify-write per cycle, sets the rate.
// Reset (aresetn low, synchronous) restores ring size 256 and an empty queue
// at once; memory entries carry valid bits, so there is no clearing pass.
// Results land in an output register: the next beat is accepted while a result
// waits on a stalled m_tready, and the engine holds its next result until the
// register frees up.
`default_nettype none

module virtqueue_descriptor_manager
    import vqdm_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [3:0]            cfg_wr_data,   // ring_size_log2
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // desc_addr, desc_len, desc_flags, chain_count, context_tag, used_id,
    // used_len, read_index, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,       // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // head_index, avail_count, done_tag, done_len, free_count, out_addr,
    // out_len, out_flags, out_next, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                 m_tuser        // status
);

    in_beat_t beat;
    result_t  res;
    logic     res_valid;
    logic     res_take;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    // unpack the input beat
    assign beat.action      = act_e_t'(s_tuser);
    assign beat.desc_addr   = s_tdata[63:0];
    assign beat.desc_len    = s_tdata[95:64];
    assign beat.desc_flags  = s_tdata[111:96];
    assign beat.chain_count = s_tdata[120:112];
    assign beat.context_tag = s_tdata[184:121];
    assign beat.used_id     = s_tdata[216:185];
    assign beat.used_len    = s_tdata[248:217];
    assign beat.read_index  = s_tdata[256:249];

    vqdm_engine #(.RING_DEPTH(RING_DEPTH)) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_beat     (beat),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= {4'd0, res.out_next, res.out_flags, res.out_len,
                            res.out_addr, res.free_count, res.done_len,
                            res.done_tag, res.avail_count, res.head_index};
            m_tuser_reg <= res.status;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
